FILE: src/kli_pkg.sv
package kli_pkg;

    // table depth and derived widths
    localparam int MAX_KEYS  = 64;
    localparam int ADDR_W    = $clog2(MAX_KEYS);
    localparam int CNT_W     = $clog2(MAX_KEYS + 1);

    // fraction is unsigned q0.16, one extra bit holds exactly 1.0
    localparam int FRAC_W    = 16;
    localparam int DIV_CNT_W = $clog2(FRAC_W + 1);

    // operation codes
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // one table entry: time and three value components
    typedef struct packed {
        logic [31:0] t;
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
    } key_t;

    // keys in use: zero reads as one, large values clamp to the depth
    function automatic logic [CNT_W-1:0] sat_count(input logic [6:0] kc);
        int v;
        v = int'(kc);
        if (v == 0)
        begin
            v = 1;
        end
        if (v > MAX_KEYS)
        begin
            v = MAX_KEYS;
        end
        return CNT_W'(v);
    endfunction

endpackage

FILE: src/keyframe_linear_interpolator.sv
// keyframe linear interpolator
// input channel (in_valid/in_ready) carries one item: a load writes one key
// (time and x/y/z value) into table slot key_index, a query gives query_time.
// output channel (out_valid/out_ready) returns one item per query: the blended
// x/y/z value and segment_start, the key that opens the chosen segment.
// loads give no output item. cfg_we/cfg_data write key_count, the keys in use.
// a load does not leave idle, so the next item is taken right after it.
// a query with more than two keys in use first scans the key times: the scan
// reads one key time per cycle from the single read port of the key memory.
// states fetch0, fetch1 and fetch2 then fetch the bracketing keys, a 16-step
// restoring divider forms the fraction (skipped when the fraction clamps or one
// key is in use), and one shared multiplier blends the three components in
// turn, with a multiply state and an add state for each component.
// one item is worked on at a time: the next item can be accepted in the cycle
// the result shows.
// a finished result waits in the output register; the next item is accepted
// meanwhile, and a second finished query holds until the receiver takes the
// first. reset empties the output register, sets key_count to 1 and leaves
// the key memory contents undefined: every slot read by a query must be loaded.
module keyframe_linear_interpolator (
    input  logic               clk,
    input  logic               rst_n,
    // input items
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               operation,
    input  logic [5:0]         key_index,
    input  logic [31:0]        key_time,
    input  logic signed [31:0] value_x,
    input  logic signed [31:0] value_y,
    input  logic signed [31:0] value_z,
    input  logic [31:0]        query_time,
    // result items
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] out_x,
    output logic signed [31:0] out_y,
    output logic signed [31:0] out_z,
    output logic [5:0]         segment_start,
    // key_count register
    input  logic               cfg_we,
    input  logic [6:0]         cfg_data
);

    localparam int ADDR_W  = kli_pkg::ADDR_W;
    localparam int FRAC_W  = kli_pkg::FRAC_W;
    localparam int PROD_W  = 33 + FRAC_W + 2;
    localparam logic [1:0] LAST_COMP = 2'd2;
    localparam logic [FRAC_W:0] FRAC_ONE = (FRAC_W + 1)'(1) << FRAC_W;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FETCH0,
        ST_FETCH1,
        ST_FETCH2,
        ST_FRAC,
        ST_DIV,
        ST_MUL,
        ST_ADD,
        ST_DONE
    } state_t;

    // key memory, one write port (loads) and one registered read port
    kli_pkg::key_t mem [kli_pkg::MAX_KEYS];
    kli_pkg::key_t rd_data_reg;
    kli_pkg::key_t wr_key;
    logic [ADDR_W-1:0] rd_addr;
    logic [ADDR_W-1:0] wr_addr;
    logic              mem_we;

    // control registers
    state_t      state_reg, state_next;
    logic        out_valid_reg, out_valid_next;
    logic [6:0]  key_count_reg, key_count_next;
    logic        chk_vld_reg, chk_vld_next;

    // query working registers
    logic [31:0]          q_reg, q_next;
    logic                 single_reg, single_next;
    logic [ADDR_W-1:0]    last_reg, last_next;
    logic [ADDR_W-1:0]    iss_reg, iss_next;
    logic [ADDR_W-1:0]    chk_idx_reg, chk_idx_next;
    logic [ADDR_W-1:0]    s_reg, s_next;
    logic [31:0]          t0_reg, t0_next;
    logic [31:0]          t1_reg, t1_next;
    logic [31:0]          rem_reg, rem_next;
    logic [31:0]          seg_reg, seg_next;
    logic [FRAC_W-1:0]    quo_reg, quo_next;
    logic [kli_pkg::DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [FRAC_W:0]      frac_reg, frac_next;
    logic [1:0]           comp_reg, comp_next;
    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic [31:0]          a_val_reg [3];
    logic [31:0]          a_val_next [3];
    logic signed [32:0]   diff_reg [3];
    logic signed [32:0]   diff_next [3];
    logic [31:0]          res_reg [3];
    logic [31:0]          res_next [3];

    // output payload registers
    logic [31:0]       out_x_reg, out_x_next;
    logic [31:0]       out_y_reg, out_y_next;
    logic [31:0]       out_z_reg, out_z_next;
    logic [5:0]        seg_out_reg, seg_out_next;

    // divider and blend datapath
    logic [32:0]              div_r2;
    logic                     div_ge;
    logic signed [PROD_W-1:0] blend_sum;
    logic [kli_pkg::CNT_W-1:0] n_keys;

    logic in_acc;

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_acc    = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_x     = out_x_reg;
    assign out_y     = out_y_reg;
    assign out_z     = out_z_reg;
    assign segment_start = seg_out_reg;

    // loads write only while idle and only reads made while busy are used, so a
    // used read never overlaps a write to the same entry
    assign mem_we  = in_acc && (operation == kli_pkg::OP_LOAD)
                     && (int'(key_index) < kli_pkg::MAX_KEYS);
    assign wr_addr = ADDR_W'(key_index);
    assign n_keys  = kli_pkg::sat_count(key_count_reg);

    always_comb
    begin
        wr_key.t = key_time;
        wr_key.x = value_x;
        wr_key.y = value_y;
        wr_key.z = value_z;
    end

    always_comb
    begin
        case (state_reg)
            ST_SCAN:   rd_addr = iss_reg;
            ST_FETCH0: rd_addr = s_reg;
            ST_FETCH1: rd_addr = s_reg + 1'b1;
            default:   rd_addr = s_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wr_addr] <= wr_key;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // restoring divide step: shifted remainder against the segment length
    assign div_r2 = {rem_reg, 1'b0};
    assign div_ge = (div_r2 >= {1'b0, seg_reg});

    // a + floor(prod / 2^16), arithmetic shift floors negative products
    assign blend_sum = $signed({{(PROD_W - 32){a_val_reg[comp_reg][31]}},
                                a_val_reg[comp_reg]})
                       + (prod_reg >>> FRAC_W);

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        key_count_next = key_count_reg;
        chk_vld_next   = chk_vld_reg;
        q_next         = q_reg;
        single_next    = single_reg;
        last_next      = last_reg;
        iss_next       = iss_reg;
        chk_idx_next   = chk_idx_reg;
        s_next         = s_reg;
        t0_next        = t0_reg;
        t1_next        = t1_reg;
        rem_next       = rem_reg;
        seg_next       = seg_reg;
        quo_next       = quo_reg;
        cnt_next       = cnt_reg;
        frac_next      = frac_reg;
        comp_next      = comp_reg;
        prod_next      = prod_reg;
        for (int k = 0; k < 3; k++)
        begin
            a_val_next[k] = a_val_reg[k];
            diff_next[k]  = diff_reg[k];
            res_next[k]   = res_reg[k];
        end
        out_x_next   = out_x_reg;
        out_y_next   = out_y_reg;
        out_z_next   = out_z_reg;
        seg_out_next = seg_out_reg;

        if (cfg_we)
        begin
            key_count_next = cfg_data;
        end

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc && (operation == kli_pkg::OP_QUERY))
                begin
                    q_next       = query_time;
                    single_next  = (n_keys == kli_pkg::CNT_W'(1));
                    last_next    = ADDR_W'(n_keys - 1'b1);
                    s_next       = '0;
                    iss_next     = ADDR_W'(1);
                    chk_vld_next = 1'b0;
                    if (n_keys > kli_pkg::CNT_W'(2))
                    begin
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        state_next = ST_FETCH0;
                    end
                end
            end
            ST_SCAN:
            begin
                // issue one key time per cycle, check the one read last cycle
                chk_vld_next = (iss_reg < last_reg);
                chk_idx_next = iss_reg;
                if (iss_reg < last_reg)
                begin
                    iss_next = iss_reg + 1'b1;
                end
                if (chk_vld_reg)
                begin
                    if (rd_data_reg.t > q_reg)
                    begin
                        s_next     = chk_idx_reg - 1'b1;
                        state_next = ST_FETCH0;
                    end
                    else if (chk_idx_reg == last_reg - 1'b1)
                    begin
                        s_next     = chk_idx_reg;
                        state_next = ST_FETCH0;
                    end
                end
            end
            ST_FETCH0:
            begin
                state_next = ST_FETCH1;
            end
            ST_FETCH1:
            begin
                t0_next       = rd_data_reg.t;
                a_val_next[0] = rd_data_reg.x;
                a_val_next[1] = rd_data_reg.y;
                a_val_next[2] = rd_data_reg.z;
                state_next    = ST_FETCH2;
            end
            ST_FETCH2:
            begin
                t1_next      = rd_data_reg.t;
                diff_next[0] = $signed({rd_data_reg.x[31], rd_data_reg.x})
                               - $signed({a_val_reg[0][31], a_val_reg[0]});
                diff_next[1] = $signed({rd_data_reg.y[31], rd_data_reg.y})
                               - $signed({a_val_reg[1][31], a_val_reg[1]});
                diff_next[2] = $signed({rd_data_reg.z[31], rd_data_reg.z})
                               - $signed({a_val_reg[2][31], a_val_reg[2]});
                // one key in use: the second read is not a key, blend adds zero
                if (single_reg)
                begin
                    for (int k = 0; k < 3; k++)
                    begin
                        diff_next[k] = '0;
                    end
                end
                state_next   = ST_FRAC;
            end
            ST_FRAC:
            begin
                comp_next = '0;
                if (single_reg || (q_reg <= t0_reg))
                begin
                    frac_next  = '0;
                    state_next = ST_MUL;
                end
                else if (q_reg >= t1_reg)
                begin
                    frac_next  = FRAC_ONE;
                    state_next = ST_MUL;
                end
                else
                begin
                    rem_next   = q_reg - t0_reg;
                    seg_next   = t1_reg - t0_reg;
                    quo_next   = '0;
                    cnt_next   = kli_pkg::DIV_CNT_W'(FRAC_W);
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_ge)
                begin
                    rem_next = 32'(div_r2 - {1'b0, seg_reg});
                end
                else
                begin
                    rem_next = div_r2[31:0];
                end
                quo_next = {quo_reg[FRAC_W-2:0], div_ge};
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == kli_pkg::DIV_CNT_W'(1))
                begin
                    frac_next  = {1'b0, quo_next};
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                prod_next  = diff_reg[comp_reg] * $signed({1'b0, frac_reg});
                state_next = ST_ADD;
            end
            ST_ADD:
            begin
                res_next[comp_reg] = blend_sum[31:0];
                if (comp_reg == LAST_COMP)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    comp_next  = comp_reg + 1'b1;
                    state_next = ST_MUL;
                end
            end
            ST_DONE:
            begin
                // hold until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    out_x_next     = res_reg[0];
                    out_y_next     = res_reg[1];
                    out_z_next     = res_reg[2];
                    seg_out_next   = 6'(s_reg);
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            key_count_reg <= 7'd1;
            chk_vld_reg   <= 1'b0;
            out_x_reg     <= '0;
            out_y_reg     <= '0;
            out_z_reg     <= '0;
            seg_out_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            key_count_reg <= key_count_next;
            chk_vld_reg   <= chk_vld_next;
            out_x_reg     <= out_x_next;
            out_y_reg     <= out_y_next;
            out_z_reg     <= out_z_next;
            seg_out_reg   <= seg_out_next;
        end
    end

    // datapath, no reset needed
    always_ff @(posedge clk)
    begin
        q_reg       <= q_next;
        single_reg  <= single_next;
        last_reg    <= last_next;
        iss_reg     <= iss_next;
        chk_idx_reg <= chk_idx_next;
        s_reg       <= s_next;
        t0_reg      <= t0_next;
        t1_reg      <= t1_next;
        rem_reg     <= rem_next;
        seg_reg     <= seg_next;
        quo_reg     <= quo_next;
        cnt_reg     <= cnt_next;
        frac_reg    <= frac_next;
        comp_reg    <= comp_next;
        prod_reg    <= prod_next;
        for (int k = 0; k < 3; k++)
        begin
            a_val_reg[k] <= a_val_next[k];
            diff_reg[k]  <= diff_next[k];
            res_reg[k]   <= res_next[k];
        end
    end

    // remainder stays below the segment length through the divide
    a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (rem_reg < seg_reg))
        else $error("divider remainder not below segment length");

    // a scan check never looks past the last start candidate
    a_scan_idx: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) && chk_vld_reg |-> (chk_idx_reg < last_reg))
        else $error("scan checked a key beyond the last segment start");

    // key memory is written only while no query is in flight
    a_we_idle: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg == ST_IDLE))
        else $error("key memory written during a query");

    // blend fraction never exceeds one
    a_frac_max: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MUL) |-> (frac_reg <= FRAC_ONE))
        else $error("blend fraction above one");

    // a finished query that finds the output free is shown next cycle
    a_done_out: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE) && (!out_valid_reg || out_ready)
        |=> out_valid_reg && (state_reg == ST_IDLE))
        else $error("finished query not moved to output");

endmodule
